// ===== src/lifh_pkg.sv =====
package lifh_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_MUL,
    ST_POST,
    ST_FINISH
  } state_t;

  // One multiply step of the Heun update; eight per time step.
  typedef logic [2:0] step_t;

  localparam step_t STP_SYN_K1   = 3'd0;
  localparam step_t STP_SYN_MID  = 3'd1;
  localparam step_t STP_SYN_K2   = 3'd2;
  localparam step_t STP_SYN_NEW  = 3'd3;
  localparam step_t STP_VOLT_K1  = 3'd4;
  localparam step_t STP_VOLT_MID = 3'd5;
  localparam step_t STP_VOLT_K2  = 3'd6;
  localparam step_t STP_VOLT_NEW = 3'd7;

  // Configuration register indexes.
  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_LEAK_RATE      = 3'd0;
  localparam reg_index_t REG_SYN_DECAY_RATE = 3'd1;
  localparam reg_index_t REG_SYN_AMPLITUDE  = 3'd2;
  localparam reg_index_t REG_FEEDBACK_AMPL  = 3'd3;
  localparam reg_index_t REG_REST_POTENTIAL = 3'd4;
  localparam reg_index_t REG_FIRE_THRESHOLD = 3'd5;
  localparam reg_index_t REG_RESET_LEVEL    = 3'd6;
  localparam reg_index_t REG_REFRACT_STEPS  = 3'd7;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic [16:0]        COUNT_MAX = 17'h1FFFF;

  // Saturate an exact 34-bit sum to signed 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [31:0] r;
    if ((x[33:31] == 3'b000) || (x[33:31] == 3'b111)) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  // Floor of (a + b) / 2; always fits in 32 bits.
  function automatic logic signed [31:0] half_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

endpackage

// ===== src/lifh_mulq.sv =====
// Shared Q16.16 multiplier: a signed value times an unsigned factor, product
// registered, then scaled by 2^-16 (floor) and saturated to 32 bits.
module lifh_mulq (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic        [31:0] b,
  output logic signed [31:0] q
);

  logic signed [64:0] prod;

  // Product register; the arithmetic shift gives rounding toward minus infinity.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, b});
    end
  end

  // Bits 64 down to 47 must all agree for the scaled value to fit.
  always_comb begin
    if ((prod[64:47] == '0) || (prod[64:47] == '1)) begin
      q = prod[47:16];
    end else if (prod[64]) begin
      q = lifh_pkg::Q_MIN;
    end else begin
      q = lifh_pkg::Q_MAX;
    end
  end

endmodule

// ===== src/lif_neuron_heun_step.sv =====
// Leaky integrate-and-fire neuron with an exponential current synapse. Each
// input beat advances the neuron by one time step using a two-stage Heun
// integration in signed Q16.16 with saturation, and yields one output beat
// with the new membrane voltage, the new synaptic current and the spike flag.
// All eight products of a step go through one shared multiplier, each passing
// through the operand, multiply and accumulate states. After the last step the
// result is loaded into the output register, and with the output free a new
// beat can be taken in the cycle after the load; the input is not ready
// meanwhile. A stalled output holds the block until its output
// register is free.
// The next beat is accepted as soon as the result is loaded, even while it
// still waits to be taken. Configuration writes are always accepted and must
// only be issued while the neuron is idle.
module lif_neuron_heun_step #(
  parameter int TIME_STEP = 655
) (
  input  logic        clk,
  input  logic        rst,
  // Input beat: [0] spike_in, [32:1] ext_current_now, [64:33] ext_current_next.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // Output beat: [31:0] membrane_voltage, [63:32] synaptic_current, [64] spike_out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [31:0] DT = 32'(TIME_STEP);

  // Configuration registers.
  logic        [30:0] leak_rate;
  logic        [30:0] syn_decay_rate;
  logic signed [31:0] syn_amplitude;
  logic signed [31:0] feedback_amplitude;
  logic signed [31:0] rest_potential;
  logic signed [31:0] fire_threshold;
  logic signed [31:0] reset_level;
  logic        [15:0] refractory_steps;

  // Neuron state.
  logic signed [31:0] voltage;
  logic signed [31:0] isyn;
  logic               fired_flag;
  logic               refractory_flag;
  logic        [16:0] refractory_count;

  // Sequencer and working registers.
  lifh_pkg::state_t   state;
  lifh_pkg::state_t   state_next;
  lifh_pkg::step_t    step;
  logic signed [31:0] drive;
  logic signed [31:0] cur_now;
  logic signed [31:0] cur_next;
  logic signed [31:0] k1;
  logic signed [31:0] k2;
  logic signed [31:0] mid;
  logic signed [31:0] opa;
  logic        [31:0] opb;
  logic signed [31:0] pq;

  // Combinational datapath signals.
  logic signed [31:0] drive_in;
  logic signed [31:0] diff;
  logic signed [31:0] opa_next;
  logic        [31:0] opb_next;
  logic signed [31:0] post_x;
  logic signed [31:0] post_z;
  logic               post_neg;
  logic signed [33:0] post_sum;
  logic signed [31:0] post_res;
  logic signed [31:0] v_pre;
  logic        [16:0] count_inc;
  logic               refr_keep;
  logic               fire;
  logic               out_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == lifh_pkg::ST_IDLE);
  assign out_load      = (state == lifh_pkg::ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // Configuration register writes; unknown indexes cannot occur with 3 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      leak_rate          <= 31'd65536;
      syn_decay_rate     <= 31'd21845;
      syn_amplitude      <= 32'sd26214400;
      feedback_amplitude <= 32'sd13107200;
      rest_potential     <= 32'sd65536;
      fire_threshold     <= 32'sd190054;
      reset_level        <= 32'sd65536;
      refractory_steps   <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lifh_pkg::REG_LEAK_RATE:      leak_rate          <= cfg_data[30:0];
        lifh_pkg::REG_SYN_DECAY_RATE: syn_decay_rate     <= cfg_data[30:0];
        lifh_pkg::REG_SYN_AMPLITUDE:  syn_amplitude      <= cfg_data;
        lifh_pkg::REG_FEEDBACK_AMPL:  feedback_amplitude <= cfg_data;
        lifh_pkg::REG_REST_POTENTIAL: rest_potential     <= cfg_data;
        lifh_pkg::REG_FIRE_THRESHOLD: fire_threshold     <= cfg_data;
        lifh_pkg::REG_RESET_LEVEL:    reset_level        <= cfg_data;
        lifh_pkg::REG_REFRACT_STEPS:  refractory_steps   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Synaptic drive from the input spike and the previous own spike.
  always_comb begin
    drive_in = lifh_pkg::sat34((s_axis_tdata[0] ? 34'(syn_amplitude) : 34'sd0)
                               + (fired_flag ? 34'(feedback_amplitude) : 34'sd0));
  end

  // Multiplier operands for the current step.
  always_comb begin
    if (step == lifh_pkg::STP_VOLT_K1) begin
      diff = lifh_pkg::sat34(34'(rest_potential) - 34'(voltage));
    end else begin
      diff = lifh_pkg::sat34(34'(rest_potential) - 34'(mid));
    end
    case (step)
      lifh_pkg::STP_SYN_K1:   opa_next = isyn;
      lifh_pkg::STP_SYN_MID:  opa_next = k1;
      lifh_pkg::STP_SYN_K2:   opa_next = mid;
      lifh_pkg::STP_SYN_NEW:  opa_next = lifh_pkg::half_sum(k1, k2);
      lifh_pkg::STP_VOLT_K1:  opa_next = diff;
      lifh_pkg::STP_VOLT_MID: opa_next = k1;
      lifh_pkg::STP_VOLT_K2:  opa_next = diff;
      lifh_pkg::STP_VOLT_NEW: opa_next = lifh_pkg::half_sum(k1, k2);
      default:                opa_next = k1;
    endcase
    if (step[0]) begin
      opb_next = DT;
    end else if (step[2]) begin
      opb_next = {1'b0, leak_rate};
    end else begin
      opb_next = {1'b0, syn_decay_rate};
    end
  end

  // Accumulate the scaled product into one or two other terms.
  always_comb begin
    post_z   = '0;
    post_neg = 1'b0;
    case (step)
      lifh_pkg::STP_SYN_K1: begin
        post_x   = drive;
        post_neg = 1'b1;
      end
      lifh_pkg::STP_SYN_MID:  post_x = isyn;
      lifh_pkg::STP_SYN_K2: begin
        post_x   = drive;
        post_neg = 1'b1;
      end
      lifh_pkg::STP_SYN_NEW:  post_x = isyn;
      lifh_pkg::STP_VOLT_K1: begin
        post_x = cur_now;
        post_z = isyn;
      end
      lifh_pkg::STP_VOLT_MID: post_x = voltage;
      lifh_pkg::STP_VOLT_K2: begin
        post_x = cur_next;
        post_z = isyn;
      end
      lifh_pkg::STP_VOLT_NEW: post_x = voltage;
      default:                post_x = voltage;
    endcase
    post_sum = 34'(post_x) + (post_neg ? -34'(pq) : 34'(pq)) + 34'(post_z);
    post_res = lifh_pkg::sat34(post_sum);
  end

  // Refractory clamp and threshold test on the integrated voltage.
  always_comb begin
    v_pre     = refractory_flag ? reset_level : mid;
    count_inc = (refractory_count != lifh_pkg::COUNT_MAX) ? refractory_count + 17'd1
                                                           : refractory_count;
    refr_keep = !(count_inc > {1'b0, refractory_steps});
    fire      = (v_pre > fire_threshold);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lifh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lifh_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = lifh_pkg::ST_OPND;
      lifh_pkg::ST_OPND:   state_next = lifh_pkg::ST_MUL;
      lifh_pkg::ST_MUL:    state_next = lifh_pkg::ST_POST;
      lifh_pkg::ST_POST: begin
        if (step == lifh_pkg::STP_VOLT_NEW) begin
          state_next = lifh_pkg::ST_FINISH;
        end else begin
          state_next = lifh_pkg::ST_OPND;
        end
      end
      lifh_pkg::ST_FINISH: if (out_load) state_next = lifh_pkg::ST_IDLE;
      default:             state_next = lifh_pkg::ST_IDLE;
    endcase
  end

  // Step counter and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lifh_pkg::STP_SYN_K1;
    end else if (s_axis_tvalid && s_axis_tready) begin
      step <= lifh_pkg::STP_SYN_K1;
    end else if ((state == lifh_pkg::ST_POST) && (step != lifh_pkg::STP_VOLT_NEW)) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      drive    <= drive_in;
      cur_now  <= s_axis_tdata[32:1];
      cur_next <= s_axis_tdata[64:33];
    end
    if (state == lifh_pkg::ST_OPND) begin
      opa <= opa_next;
      opb <= opb_next;
    end
    if (state == lifh_pkg::ST_POST) begin
      case (step)
        lifh_pkg::STP_SYN_K1, lifh_pkg::STP_VOLT_K1:   k1  <= post_res;
        lifh_pkg::STP_SYN_K2, lifh_pkg::STP_VOLT_K2:   k2  <= post_res;
        lifh_pkg::STP_SYN_NEW:                         ;
        default:                                       mid <= post_res;
      endcase
    end
  end

  // Neuron state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage          <= lifh_pkg::Q_ONE;
      isyn             <= lifh_pkg::Q_ONE;
      fired_flag       <= 1'b0;
      refractory_flag  <= 1'b0;
      refractory_count <= '0;
    end else begin
      if ((state == lifh_pkg::ST_POST) && (step == lifh_pkg::STP_SYN_NEW)) begin
        isyn <= post_res;
      end
      if (out_load) begin
        fired_flag <= fire;
        if (fire) begin
          voltage          <= reset_level;
          refractory_flag  <= 1'b1;
          refractory_count <= '0;
        end else begin
          voltage <= v_pre;
          if (refractory_flag) begin
            refractory_count <= count_inc;
            refractory_flag  <= refr_keep;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, fire, isyn, (fire ? reset_level : v_pre)};
    end
  end

  lifh_mulq u_mulq (
    .clk (clk),
    .en  (state == lifh_pkg::ST_MUL),
    .a   (opa),
    .b   (opb),
    .q   (pq)
  );

  // An accepted beat always starts the sequence at its first step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=>
      (state == lifh_pkg::ST_OPND) && (step == lifh_pkg::STP_SYN_K1))
    else $error("sequence did not start at the first step");

  // Steps advance by one after each accumulate.
  a_step: assert property (@(posedge clk) disable iff (rst)
    ((state == lifh_pkg::ST_POST) && (step != lifh_pkg::STP_VOLT_NEW)) |=>
      (state == lifh_pkg::ST_OPND) && (step == $past(step) + 3'd1))
    else $error("step counter out of sequence");

  // A neuron that has just fired is always refractory.
  a_fire_refr: assert property (@(posedge clk) disable iff (rst)
    fired_flag |-> refractory_flag)
    else $error("fired without refractory period");

  // A spiking result carries the reset level as its voltage.
  a_spike_level: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[64]) |-> (m_axis_tdata[31:0] == reset_level))
    else $error("spike result voltage is not the reset level");

endmodule
